/* src/kas_pkg.sv */
// ----------------------------------------------------------------------------
// kas_pkg: shared types and constants for the key autorepeat scroll block
// Payload structs, axis phase codes, register map and fixed field widths.
// ----------------------------------------------------------------------------
package kas_pkg;

  localparam int BTN_W            = 11;
  localparam int BUTTON_COUNT_DEF = 11;
  localparam int DT_W             = 18;
  localparam int REG_W            = 20;
  localparam int MOUSE_W          = 12;
  localparam int SCROLL_W         = 16;
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;

  localparam logic [REG_W-1:0] HOLD_DELAY_RST   = 20'd250000;
  localparam logic [REG_W-1:0] REPEAT_PERIOD_RST = 20'd100000;
  localparam logic [REG_W-1:0] DWELL_MAX        = 20'hFFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_HOLD_DELAY    = 1'b0;
  localparam logic REG_REPEAT_PERIOD = 1'b1;

  // axis phase codes
  localparam logic [1:0] PH_NONE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_STALLED = 2'd2;
  localparam logic [1:0] PH_HELD    = 2'd3;

  typedef struct packed {
    logic [BTN_W-1:0]          buttons;
    logic                      mouse_button_down;
    logic signed [MOUSE_W-1:0] mouse_dx;
    logic signed [MOUSE_W-1:0] mouse_dy;
    logic [DT_W-1:0]           delta_time_us;
  } in_t;

  typedef struct packed {
    logic signed [SCROLL_W-1:0] scroll_x;
    logic signed [SCROLL_W-1:0] scroll_y;
    logic [1:0]                 phase_x;
    logic [1:0]                 phase_y;
    logic [BTN_W-1:0]           pressed_edges;
    logic [BTN_W-1:0]           released_edges;
  } out_t;

endpackage

/* src/key_autorepeat_scroll.sv */
// ----------------------------------------------------------------------------
// key_autorepeat_scroll: typematic autorepeat and scroll step generator
// Button edges, per-axis none/pressed/stalled/held phases and repeat steps
// from a shared multiplier and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// Sequence: an input transfer moves the sequencer from idle to S_MUL; each
//   held axis adds one multiply, one add and, unless acc plus product is zero,
//   31 divide steps. The 31-bit divide by the repeat period is the longest part.
// Flow: one item at a time; the next item is taken once the sequencer
//   is back in idle, after S_OUT has loaded the result of the previous one.
// Reset: synchronous active-low rst_n clears phases, dwell times, repeat
//   accumulators, previous buttons and restores the register defaults.

module key_autorepeat_scroll
  import kas_pkg::*;
#(
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int SUM_W  = 13;
  localparam int MAG_W  = 12;
  localparam int PROD_W = DT_W + MAG_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(NUM_W);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_DIV, S_OUT} state_t;

  state_t                   state_r;
  logic                     ax_r;
  logic [REG_W-1:0]         hold_delay_r, period_r;
  logic [BTN_W-1:0]         prev_btn_r;
  logic [1:0]               phase_r [2];
  logic [REG_W-1:0]         dwell_r [2];
  logic [REG_W-1:0]         acc_r   [2];
  logic signed [SUM_W-1:0]  sum_r   [2];
  logic signed [SCROLL_W-1:0] steps_r [2];
  logic [DT_W-1:0]          dt_r;
  logic [BTN_W-1:0]         pe_r, re_r;
  logic [PROD_W-1:0]        prod_r;
  logic [NUM_W-1:0]         quo_r;
  logic [REG_W-1:0]         rem_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r;
  out_t                     out_r;

  // ---------------- input decode ----------------
  logic [BTN_W-1:0]         btn_mask, now;
  logic signed [SUM_W-1:0]  lx, ly, sel_x, sel_y;
  logic [SUM_W-1:0]         lx_abs, ly_abs;
  logic                     up, down, left, right, diag;
  logic signed [SUM_W-1:0]  dig [2];
  logic [1:0]               phase_nxt [2];
  logic [REG_W-1:0]         dwell_nxt [2];
  logic [REG_W:0]           dwell_sum [2];
  logic [REG_W-1:0]         dwell_sat [2];
  logic                     in_xfer, cfg_wr;

  assign in_xfer = in_valid && in_ready;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    for (int i = 0; i < BTN_W; i++) begin
      btn_mask[i] = (i < BUTTON_COUNT);
    end
  end

  assign now   = in_data.buttons & btn_mask;
  assign lx    = in_data.mouse_button_down ? SUM_W'(in_data.mouse_dx) : '0;
  assign ly    = in_data.mouse_button_down ? -SUM_W'(in_data.mouse_dy) : '0;
  assign lx_abs = lx[SUM_W-1] ? SUM_W'(-lx) : SUM_W'(lx);
  assign ly_abs = ly[SUM_W-1] ? SUM_W'(-ly) : SUM_W'(ly);
  // y wins a tie in magnitude
  assign sel_y = (ly_abs >= lx_abs) ? ly : '0;
  assign sel_x = (ly_abs >= lx_abs) ? '0 : lx;

  assign diag  = (now[2] || now[3]) && (now[0] || now[1]);
  assign up    = now[0] && !diag;
  assign down  = now[1] && !diag;
  assign left  = now[2] && !diag;
  assign right = now[3] && !diag;
  assign dig[0] = SUM_W'(right) - SUM_W'(left);
  assign dig[1] = SUM_W'(up) - SUM_W'(down);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dwell_sum[i] = {1'b0, dwell_r[i]} + (REG_W+1)'(in_data.delta_time_us);
      dwell_sat[i] = dwell_sum[i][REG_W] ? DWELL_MAX : dwell_sum[i][REG_W-1:0];
      phase_nxt[i] = phase_r[i];
      dwell_nxt[i] = dwell_r[i];
      if (dig[i] == '0) begin
        phase_nxt[i] = PH_NONE;
        dwell_nxt[i] = '0;
      end else begin
        case (phase_r[i])
          PH_NONE: begin
            phase_nxt[i] = PH_PRESSED;
          end
          PH_PRESSED: begin
            phase_nxt[i] = PH_STALLED;
            dwell_nxt[i] = '0;
          end
          PH_STALLED: begin
            if (dwell_sat[i] > hold_delay_r) begin
              phase_nxt[i] = PH_HELD;
              dwell_nxt[i] = '0;
            end else begin
              dwell_nxt[i] = dwell_sat[i];
            end
          end
          default: begin
            dwell_nxt[i] = dwell_sat[i];
          end
        endcase
      end
    end
  end

  // ---------------- shared datapath ----------------
  logic signed [SUM_W-1:0]  cur_sum;
  logic [MAG_W-1:0]         cur_mag;
  logic                     cur_neg;
  logic [REG_W-1:0]         per_eff;
  logic [NUM_W-1:0]         num;
  logic [REG_W:0]           rem_sh;
  logic                     rem_ge;
  logic [REG_W-1:0]         rem_nxt;
  logic [NUM_W-1:0]         quo_nxt;
  logic signed [SCROLL_W-1:0] sat_steps;

  assign cur_sum = sum_r[ax_r];
  assign cur_neg = cur_sum[SUM_W-1];
  assign cur_mag = cur_neg ? MAG_W'(-cur_sum) : MAG_W'(cur_sum);
  assign per_eff = (period_r == '0) ? REG_W'(1) : period_r;
  assign num     = NUM_W'(acc_r[ax_r]) + NUM_W'(prod_r);

  // one restoring divide step: remainder stays below the period
  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, per_eff};
  assign rem_nxt = rem_ge ? REG_W'(rem_sh - {1'b0, per_eff}) : rem_sh[REG_W-1:0];
  assign quo_nxt = {quo_r[NUM_W-2:0], rem_ge};

  always_comb begin
    if (cur_neg) begin
      sat_steps = (quo_nxt > NUM_W'(32768)) ? 16'sh8000 : SCROLL_W'(-quo_nxt);
    end else begin
      sat_steps = (quo_nxt > NUM_W'(32767)) ? 16'sh7FFF : SCROLL_W'(quo_nxt);
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ax_r         <= 1'b0;
      hold_delay_r <= HOLD_DELAY_RST;
      period_r     <= REPEAT_PERIOD_RST;
      prev_btn_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        phase_r[i] <= PH_NONE;
        dwell_r[i] <= '0;
        acc_r[i]   <= '0;
      end
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          REG_HOLD_DELAY:    hold_delay_r <= cfg_pwdata[REG_W-1:0];
          REG_REPEAT_PERIOD: period_r     <= cfg_pwdata[REG_W-1:0];
          default: ;
        endcase
      end

      // in S_OUT the output register is reloaded below instead
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            pe_r       <= now & ~prev_btn_r;
            re_r       <= ~now & prev_btn_r;
            prev_btn_r <= now;
            dt_r       <= in_data.delta_time_us;
            sum_r[0]   <= dig[0] + sel_x;
            sum_r[1]   <= dig[1] + sel_y;
            for (int i = 0; i < 2; i++) begin
              phase_r[i] <= phase_nxt[i];
              dwell_r[i] <= dwell_nxt[i];
            end
            ax_r    <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (phase_r[ax_r] == PH_HELD) begin
            prod_r  <= PROD_W'(dt_r) * PROD_W'(cur_mag);
            state_r <= S_ADD;
          end else begin
            if (phase_r[ax_r] == PH_PRESSED) begin
              steps_r[ax_r] <= cur_neg ? -16'sd1 : 16'sd1;
              acc_r[ax_r]   <= '0;
            end else begin
              steps_r[ax_r] <= '0;
            end
            ax_r    <= 1'b1;
            state_r <= ax_r ? S_OUT : S_MUL;
          end
        end
        S_ADD: begin
          if (num == '0) begin
            steps_r[ax_r] <= '0;
            ax_r          <= 1'b1;
            state_r       <= ax_r ? S_OUT : S_MUL;
          end else begin
            // steps = (acc - 1) / period, new acc = remainder + 1
            quo_r   <= num - NUM_W'(1);
            rem_r   <= '0;
            cnt_r   <= CNT_W'(NUM_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            steps_r[ax_r] <= sat_steps;
            acc_r[ax_r]   <= rem_nxt + REG_W'(1);
            ax_r          <= 1'b1;
            state_r       <= ax_r ? S_OUT : S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.scroll_x       <= steps_r[0];
            out_r.scroll_y       <= steps_r[1];
            out_r.phase_x        <= phase_r[0];
            out_r.phase_y        <= phase_r[1];
            out_r.pressed_edges  <= pe_r;
            out_r.released_edges <= re_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_REPEAT_PERIOD) ? DATA_W'(period_r)
                                                          : DATA_W'(hold_delay_r);

endmodule

/* src/kas_chk.sv */
// ----------------------------------------------------------------------------
// kas_chk: port-level checks for key_autorepeat_scroll
// Watches the handshakes and the consistency of each result transfer.
// ----------------------------------------------------------------------------
module kas_chk
  import kas_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: no input transfer right after another
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // an x axis that is neither pressed nor held gives no steps
  a_idle_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase_x == PH_NONE || out_data.phase_x == PH_STALLED)
      |-> out_data.scroll_x == 16'sd0)
    else $error("steps from an idle x axis");

  // a pressed y axis gives exactly one step, of either sign
  a_press_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.phase_y == PH_PRESSED
      |-> (out_data.scroll_y == 16'sd1 || out_data.scroll_y == -16'sd1))
    else $error("pressed y axis without a single step");

  // a button cannot both press and release in one frame
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pressed_edges & out_data.released_edges) == '0)
    else $error("overlapping press and release edges");

endmodule

bind key_autorepeat_scroll kas_chk u_kas_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/scroll_checker.sv */
// ----------------------------------------------------------------------------
// scroll_checker: frame predictor and result comparator
// Follows register writes on the config port, predicts the result of every
// accepted frame and compares each result transfer, field by field, against
// the oldest prediction.
// ----------------------------------------------------------------------------
module scroll_checker
  import kas_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output int                error_count,
  output int                result_count
);

  localparam logic [BTN_W-1:0] BTN_MASK = BTN_W'((1 << BUTTON_COUNT_DEF) - 1);

  // predictor state
  logic [REG_W-1:0] hold_us;
  logic [REG_W-1:0] period_us;
  logic [BTN_W-1:0] last_btn;
  logic [1:0]       phase [2];
  logic [REG_W-1:0] dwell [2];
  logic [31:0]      accum [2];

  out_t pending_scrolls[$];
  out_t oldest;
  int   fails = 0;
  int   got = 0;

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void step_phase(int a, int dig, logic [DT_W-1:0] dt);
    logic [REG_W:0] t;
    if (dig == 0) begin
      phase[a] = PH_NONE;
      dwell[a] = '0;
      return;
    end
    case (phase[a])
      PH_NONE: phase[a] = PH_PRESSED;
      PH_PRESSED: begin
        phase[a] = PH_STALLED;
        dwell[a] = '0;
      end
      default: begin
        t = dwell[a] + dt;
        dwell[a] = (t > DWELL_MAX) ? DWELL_MAX : t[REG_W-1:0];
        if (phase[a] == PH_STALLED && dwell[a] > hold_us) begin
          phase[a] = PH_HELD;
          dwell[a] = '0;
        end
      end
    endcase
  endfunction

  // steps for one axis after its phase update; sum is digital plus mouse
  function automatic logic [SCROLL_W-1:0] axis_count(int a, int sum, logic [DT_W-1:0] dt);
    longint period, acc, k, steps;
    steps = 0;
    if (phase[a] == PH_HELD) begin
      period = period_us;
      if (period == 0) period = 1;
      acc = accum[a];
      acc += longint'(dt) * magnitude(sum);
      k = (acc > period) ? (acc - 1) / period : 0;
      acc -= k * period;
      accum[a] = 32'(acc);
      steps = (sum < 0) ? -k : k;
    end else if (phase[a] == PH_PRESSED) begin
      steps = (sum < 0) ? -1 : 1;
      accum[a] = '0;
    end
    if (steps > 32767) steps = 32767;
    else if (steps < -32768) steps = -32768;
    return SCROLL_W'(steps);
  endfunction

  function automatic out_t predict_frame(in_t f);
    out_t r;
    logic [BTN_W-1:0] now;
    int up, dn, lf, rt, dig_x, dig_y, mx, my, ax, ay;
    now = f.buttons & BTN_MASK;
    r.pressed_edges = now & ~last_btn;
    r.released_edges = ~now & last_btn;
    last_btn = now;
    mx = 0;
    my = 0;
    ax = 0;
    ay = 0;
    if (f.mouse_button_down) begin
      mx = f.mouse_dx;
      my = -int'(f.mouse_dy);
    end
    up = now[0];
    dn = now[1];
    lf = now[2];
    rt = now[3];
    // a horizontal and a vertical arrow together cancel both axes
    if ((rt || lf) && (up || dn)) begin
      up = 0;
      dn = 0;
      lf = 0;
      rt = 0;
    end
    dig_x = rt - lf;
    dig_y = up - dn;
    step_phase(0, dig_x, f.delta_time_us);
    step_phase(1, dig_y, f.delta_time_us);
    // dominant mouse axis only, y wins a tie
    if (magnitude(my) >= magnitude(mx)) ay = my;
    else ax = mx;
    r.scroll_x = axis_count(0, dig_x + ax, f.delta_time_us);
    r.scroll_y = axis_count(1, dig_y + ay, f.delta_time_us);
    r.phase_x = phase[0];
    r.phase_y = phase[1];
    return r;
  endfunction

  task automatic check_field(string name, int want, int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_us = HOLD_DELAY_RST;
      period_us = REPEAT_PERIOD_RST;
      last_btn = '0;
      for (int a = 0; a < 2; a++) begin
        phase[a] = PH_NONE;
        dwell[a] = '0;
        accum[a] = '0;
      end
      pending_scrolls.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_HOLD_DELAY) hold_us = cfg_pwdata[REG_W-1:0];
        else period_us = cfg_pwdata[REG_W-1:0];
      end
      if (out_valid && out_ready) begin
        got++;
        if (pending_scrolls.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fails++;
        end else begin
          oldest = pending_scrolls.pop_front();
          check_field("scroll_x", int'(oldest.scroll_x), int'(out_data.scroll_x));
          check_field("scroll_y", int'(oldest.scroll_y), int'(out_data.scroll_y));
          check_field("phase_x", int'(oldest.phase_x), int'(out_data.phase_x));
          check_field("phase_y", int'(oldest.phase_y), int'(out_data.phase_y));
          check_field("pressed_edges", int'(oldest.pressed_edges),
                      int'(out_data.pressed_edges));
          check_field("released_edges", int'(oldest.released_edges),
                      int'(out_data.released_edges));
        end
      end
      if (in_valid && in_ready) pending_scrolls.push_back(predict_frame(in_data));
    end
    error_count <= fails;
    result_count <= got;
  end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench top for key_autorepeat_scroll
// Drives a short directed frame sequence, then arrow-key gestures with random
// mouse, timing and noise under several register settings, with random gaps
// and stalls on both channels. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import kas_pkg::*;

  localparam logic [BTN_W-1:0] ARROW_UP    = 11'h001;
  localparam logic [BTN_W-1:0] ARROW_DOWN  = 11'h002;
  localparam logic [BTN_W-1:0] ARROW_LEFT  = 11'h004;
  localparam logic [BTN_W-1:0] ARROW_RIGHT = 11'h008;
  localparam int ITEMS_PER_SETTING = 130;
  localparam int SETTINGS_COUNT = 6;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_t               in_data;
  logic              out_valid;
  logic              out_ready;
  out_t              out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;
  int                error_count;
  int                result_count;

  int n_sent = 0;
  int n_writes = 0;
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;

  always #1 clk = ~clk;

  key_autorepeat_scroll u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  scroll_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .error_count (error_count),
    .result_count(result_count)
  );

  function automatic in_t frame(logic [BTN_W-1:0] b, logic m, int dx, int dy, int dt);
    in_t f;
    f.buttons = b;
    f.mouse_button_down = m;
    f.mouse_dx = MOUSE_W'(dx);
    f.mouse_dy = MOUSE_W'(dy);
    f.delta_time_us = DT_W'(dt);
    return f;
  endfunction

  task automatic send_frame(in_t f);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_count != n_sent);
  endtask

  // setup cycle, access cycle, then back to idle
  task automatic write_reg(logic idx, logic [REG_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {(DATA_W-REG_W)'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // one arrow gesture held over up to 28 frames, with noise mixed in
  task automatic run_gesture();
    logic [BTN_W-1:0] arrows, extra, btn;
    int kind, len, dx, dy, dt, r;
    bit slow;
    kind = $urandom_range(0, 15);
    if (kind <= 8) arrows = ARROW_UP << $urandom_range(0, 3);
    else if (kind <= 10) arrows = '0;
    else if (kind <= 12)
      arrows = ($urandom_range(0, 1) ? ARROW_UP : ARROW_DOWN) |
               ($urandom_range(0, 1) ? ARROW_LEFT : ARROW_RIGHT);
    else if (kind == 13)
      arrows = $urandom_range(0, 1) ? (ARROW_UP | ARROW_DOWN) : (ARROW_LEFT | ARROW_RIGHT);
    else arrows = BTN_W'($urandom_range(0, 15));
    len = (kind <= 8) ? $urandom_range(1, 28) : $urandom_range(1, 6);
    slow = ($urandom_range(0, 3) == 0);
    extra = BTN_W'($urandom) & ~BTN_W'(15);
    if ($urandom_range(0, 5) == 0) sender_gaps = !sender_gaps;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) extra = BTN_W'($urandom) & ~BTN_W'(15);
      btn = arrows | extra;
      if ($urandom_range(0, 15) == 0) btn = BTN_W'($urandom);
      if ($urandom_range(0, 5) == 0) begin
        dx = $urandom_range(0, 4095);
        dy = $urandom_range(0, 4095);
      end else begin
        dx = $urandom_range(0, 48) - 24;
        dy = $urandom_range(0, 48) - 24;
      end
      r = $urandom_range(0, 15);
      if (r == 0) dt = 0;
      else if (r <= 2) dt = $urandom_range(0, 262143);
      else if (r == 3) dt = 262143;
      else if (slow) dt = $urandom_range(100000, 262143);
      else dt = $urandom_range(4000, 40000);
      send_frame(frame(btn, $urandom_range(0, 2) == 0, dx, dy, dt));
    end
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      int stall;
      if ($urandom_range(0, 19) == 0) receiver_stalls = !receiver_stalls;
      stall = receiver_stalls ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [REG_W-1:0] hold_val, period_val;
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at reset register values
    send_frame(frame('0, 1'b0, 0, 0, 0));
    send_frame(frame(11'h7FF, 1'b1, 2047, -2048, 262143));
    send_frame(frame('0, 1'b1, -2048, 2047, 0));
    send_frame(frame(ARROW_UP, 1'b0, 0, 0, 262143));
    send_frame(frame(ARROW_UP, 1'b0, 0, 0, 262143));
    send_frame(frame(ARROW_UP, 1'b0, 0, 0, 262143));
    send_frame(frame(ARROW_UP, 1'b1, 3, -40, 50000));
    send_frame(frame(ARROW_UP, 1'b1, -7, 7, 100000));   // tie, y wins
    send_frame(frame(ARROW_UP, 1'b1, 0, 1, 100000));    // held, zero sum
    send_frame(frame('0, 1'b0, 0, 0, 20000));
    send_frame(frame(ARROW_DOWN, 1'b1, 0, 5, 1000));
    send_frame(frame(ARROW_DOWN, 1'b1, 0, -1, 0));
    send_frame(frame(ARROW_LEFT, 1'b0, 0, 0, 30000));
    send_frame(frame(ARROW_LEFT, 1'b1, 2047, 0, 0));
    send_frame(frame(ARROW_RIGHT, 1'b1, -2048, 0, 5));
    send_frame(frame(ARROW_LEFT | ARROW_RIGHT, 1'b1, 9, 1, 16000));
    send_frame(frame(ARROW_RIGHT, 1'b0, 100, 100, 0));
    send_frame(frame(ARROW_RIGHT | ARROW_UP, 1'b1, 1, 2, 262143));
    send_frame(frame(11'h7F0, 1'b1, 0, 0, 777));
    send_frame(frame('0, 1'b0, 0, 0, 0));

    target = n_sent;
    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      case (s)
        0: begin hold_val = '0; period_val = REG_W'(1); end
        1: begin hold_val = DWELL_MAX; period_val = DWELL_MAX; end
        2: begin hold_val = '0; period_val = '0; end
        3: begin hold_val = REG_W'(30000); period_val = REG_W'(7000); end
        4: begin
          hold_val = REG_W'($urandom_range(0, 400000));
          period_val = REG_W'($urandom_range(1, 300000));
        end
        default: begin hold_val = HOLD_DELAY_RST; period_val = REPEAT_PERIOD_RST; end
      endcase
      wait_drained();
      write_reg(REG_HOLD_DELAY, hold_val);
      write_reg(REG_REPEAT_PERIOD, period_val);
      target += ITEMS_PER_SETTING;
      while (n_sent < target) begin
        run_gesture();
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("ran %0d frames through %0d register writes in %0d settings, %0d results checked",
             n_sent, n_writes, SETTINGS_COUNT + 1, result_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
